### sv/uart_8n1_with_rx_fifo_core_assert.svh
// ----------------------------------------------------------------------------
// UART 8N1 core assertion macros
// Concurrent assertion helpers shared by the RTL. Synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef UART_8N1_WITH_RX_FIFO_CORE_ASSERT_SVH
`define UART_8N1_WITH_RX_FIFO_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication: when ante holds, cons must hold at that edge.
`define U8_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("u8n1rxf: same-cycle check failed");
// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define U8_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("u8n1rxf: next-cycle check failed");
`else
`define U8_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define U8_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

### sv/u8n1rxf_pkg.sv
// ----------------------------------------------------------------------------
// UART 8N1 core package
// Shared types and constants of the UART transceiver with receive FIFO.
// ----------------------------------------------------------------------------
package u8n1rxf_pkg;

   typedef logic [7:0] byte_type;

   localparam int FIFO_DEPTH_DEFAULT = 64;

   localparam int          BIT_PERIOD_W     = 16;
   localparam logic [15:0] BIT_PERIOD_RESET = 16'd103;

   // A frame is start bit, eight data bits and stop bit.
   localparam logic [3:0] FRAME_BITS    = 4'd10;
   localparam logic [9:0] TX_IDLE_FRAME = 10'h3FF;

   // Receiver slot numbers: zero waits out the start bit, nine is the stop slot.
   localparam logic [3:0] RX_SLOT_START = 4'd0;
   localparam logic [3:0] RX_SLOT_FIRST = 4'd1;
   localparam logic [3:0] RX_SLOT_LAST  = 4'd8;

   // Configuration port.
   localparam int   CSR_ADDR_W          = 3;
   localparam int   CSR_DATA_W          = 32;
   localparam logic REG_BIT_PERIOD_IDX  = 1'b0;

endpackage

### sv/u8n1rxf_if.sv
// ----------------------------------------------------------------------------
// UART 8N1 core channel interfaces
// Valid/ready channels for the tick words going in and the status words out.
// ----------------------------------------------------------------------------
interface u8n1rxf_req_if;
   logic                   valid;
   logic                   ready;
   logic                   rx_line;
   logic                   tx_valid;
   u8n1rxf_pkg::byte_type  tx_data;
   logic                   rx_pop;

   modport source (output valid, rx_line, tx_valid, tx_data, rx_pop, input ready);
   modport sink   (input valid, rx_line, tx_valid, tx_data, rx_pop, output ready);
endinterface

interface u8n1rxf_rsp_if;
   logic                   valid;
   logic                   ready;
   logic                   tx_line;
   logic                   tx_busy;
   logic                   rx_available;
   u8n1rxf_pkg::byte_type  rx_data;
   logic                   rx_overrun;

   modport source (output valid, tx_line, tx_busy, rx_available, rx_data, rx_overrun,
                   input ready);
   modport sink   (input valid, tx_line, tx_busy, rx_available, rx_data, rx_overrun,
                   output ready);
endinterface

### sv/u8n1rxf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered, old data on a
// read of the address being written.
// ----------------------------------------------------------------------------
module u8n1rxf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/uart_8n1_with_rx_fifo_core.sv
// ----------------------------------------------------------------------------
// UART 8N1 transceiver with receive FIFO
// Tick-driven 8N1 transmitter and receiver; received bytes queue in a RAM.
// ----------------------------------------------------------------------------
// Usage:
// Each word on req is one bit-timer tick: the sampled receive line, an
// optional byte to send and an optional pop of the receive FIFO. For every
// accepted word exactly one status word leaves on rsp: transmit line level,
// busy flag, FIFO-not-empty flag, head byte of the FIFO and an overrun flag.
// A word accepted at one edge passes the RAM read stage and the output queue
// before rsp offers it; the FIFO RAM gives the head byte in the cycle after
// the state update. One word is accepted every cycle while rsp keeps up.
// Results sit in a two-entry output queue (output register plus skid), so
// req stays ready while one result waits. When rsp stalls, req drops ready
// once two words wait between the RAM read stage and the queue, and rises
// again in the cycle a result is taken. Reset (synchronous, active high)
// clears the timers, the pointers and the output queue; the FIFO RAM is not
// cleared and needs no clearing pass, since only entries already written
// are ever read.
// The user writes the bit period register over the APB-style csr port only
// while no word is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "uart_8n1_with_rx_fifo_core_assert.svh"

module uart_8n1_with_rx_fifo_core #(
   parameter int FIFO_DEPTH = u8n1rxf_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   u8n1rxf_req_if.sink                          req,
   u8n1rxf_rsp_if.source                        rsp,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [u8n1rxf_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [u8n1rxf_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [u8n1rxf_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam int BP_W  = u8n1rxf_pkg::BIT_PERIOD_W;

   typedef struct packed {
      logic                  tx_line;
      logic                  tx_busy;
      logic                  rx_available;
      logic                  rx_overrun;
      logic                  fwd;
      u8n1rxf_pkg::byte_type fwd_data;
   } stage_type;

   typedef struct packed {
      logic                  tx_line;
      logic                  tx_busy;
      logic                  rx_available;
      u8n1rxf_pkg::byte_type rx_data;
      logic                  rx_overrun;
   } rsp_entry_type;

   function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(FIFO_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   // Configuration register.
   logic [BP_W-1:0] bit_period_ff, bit_period_in;
   logic            csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == u8n1rxf_pkg::REG_BIT_PERIOD_IDX);
   assign bit_period_in = csr_wr ? csr_pwdata[BP_W-1:0] : bit_period_ff;
   assign csr_prdata = (csr_paddr[2] == u8n1rxf_pkg::REG_BIT_PERIOD_IDX) ?
                       {{(u8n1rxf_pkg::CSR_DATA_W-BP_W){1'b0}}, bit_period_ff} : '0;

   // Transmitter, receiver and FIFO control state.
   logic [9:0]            tx_shift_ff, tx_shift_in;
   logic [3:0]            tx_bits_ff, tx_bits_in;
   logic                  tx_active_ff, tx_active_in;
   logic [BP_W-1:0]       tx_tick_ff, tx_tick_in;
   logic                  rx_active_ff, rx_active_in;
   logic [BP_W-1:0]       rx_tick_ff, rx_tick_in;
   logic [3:0]            rx_slot_ff, rx_slot_in;
   u8n1rxf_pkg::byte_type rx_asm_ff, rx_asm_in;
   logic                  rx_prev_ff, rx_prev_in;
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   // RAM read stage and output queue.
   logic                  p1_valid_ff, p1_valid_in;
   stage_type             p1_ff, p1_in;
   rsp_entry_type         outq_ff [2];
   rsp_entry_type         outq_in [2];
   logic [1:0]            outq_cnt_ff, outq_cnt_in;

   logic                  fire;
   logic                  rsp_pop;
   logic                  push_en;
   logic                  overrun;
   logic [CNT_W-1:0]      count_pop;
   logic [BP_W-1:0]       rx_limit;
   logic [2:0]            rx_bit_idx;
   u8n1rxf_pkg::byte_type ram_rd_data;
   rsp_entry_type         p1_entry;
   logic [1:0]            occupancy;

   assign rsp_pop   = rsp.valid && rsp.ready;
   assign occupancy = outq_cnt_ff + {1'b0, p1_valid_ff};
   assign req.ready = (occupancy < 2'd2) || rsp_pop;
   assign fire      = req.valid && req.ready;
   assign rx_limit  = (rx_slot_ff == u8n1rxf_pkg::RX_SLOT_START) ?
                      (bit_period_ff >> 1) : bit_period_ff;
   assign rx_bit_idx = rx_slot_ff[2:0] - 3'd1;

   always_comb begin
      tx_shift_in  = tx_shift_ff;
      tx_bits_in   = tx_bits_ff;
      tx_active_in = tx_active_ff;
      tx_tick_in   = tx_tick_ff;
      rx_active_in = rx_active_ff;
      rx_tick_in   = rx_tick_ff;
      rx_slot_in   = rx_slot_ff;
      rx_asm_in    = rx_asm_ff;
      rx_prev_in   = rx_prev_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      count_pop    = count_ff;
      count_in     = count_ff;
      push_en      = 1'b0;
      overrun      = 1'b0;

      if (fire) begin
         // The pop frees its entry before the receiver may push.
         if (req.rx_pop && (count_ff != '0)) begin
            rd_ptr_in = wrap_next(rd_ptr_ff);
            count_pop = count_ff - CNT_W'(1);
         end

         if (rx_active_ff) begin
            if (rx_tick_ff >= rx_limit) begin
               rx_tick_in = '0;
               if ((rx_slot_ff >= u8n1rxf_pkg::RX_SLOT_FIRST) &&
                   (rx_slot_ff <= u8n1rxf_pkg::RX_SLOT_LAST)) begin
                  rx_asm_in[rx_bit_idx] = rx_asm_ff[rx_bit_idx] | req.rx_line;
                  rx_slot_in = rx_slot_ff + 4'd1;
               end else if (rx_slot_ff == u8n1rxf_pkg::RX_SLOT_START) begin
                  rx_slot_in = u8n1rxf_pkg::RX_SLOT_FIRST;
               end else begin
                  if (count_pop < CNT_W'(FIFO_DEPTH)) begin
                     push_en   = 1'b1;
                     wr_ptr_in = wrap_next(wr_ptr_ff);
                  end else begin
                     overrun = 1'b1;
                  end
                  rx_active_in = 1'b0;
                  rx_slot_in   = u8n1rxf_pkg::RX_SLOT_START;
                  rx_asm_in    = '0;
               end
            end else begin
               rx_tick_in = rx_tick_ff + BP_W'(1);
            end
         end else if (rx_prev_ff && !req.rx_line) begin
            rx_active_in = 1'b1;
            rx_tick_in   = '0;
            rx_slot_in   = u8n1rxf_pkg::RX_SLOT_START;
            rx_asm_in    = '0;
         end
         rx_prev_in = req.rx_line;
         count_in   = count_pop + CNT_W'(push_en);

         if (tx_active_ff) begin
            if (tx_tick_ff >= bit_period_ff) begin
               tx_tick_in  = '0;
               tx_shift_in = {1'b1, tx_shift_ff[9:1]};
               tx_bits_in  = (tx_bits_ff != 4'd0) ? (tx_bits_ff - 4'd1) : tx_bits_ff;
               if (tx_bits_in == 4'd0) begin
                  tx_active_in = 1'b0;
                  tx_shift_in  = u8n1rxf_pkg::TX_IDLE_FRAME;
               end
            end else begin
               tx_tick_in = tx_tick_ff + BP_W'(1);
            end
         end

         // A byte offered on the tick a frame ends starts its own frame at once.
         if (req.tx_valid && !tx_active_in) begin
            tx_shift_in  = {1'b1, req.tx_data, 1'b0};
            tx_bits_in   = u8n1rxf_pkg::FRAME_BITS;
            tx_tick_in   = '0;
            tx_active_in = 1'b1;
         end
      end
   end

   // The RAM returns old data when the head entry is written in the same cycle
   // (FIFO empty once any pop of the tick is done); that byte is forwarded.
   always_comb begin
      p1_valid_in          = fire;
      p1_in.tx_line        = tx_active_in ? tx_shift_in[0] : 1'b1;
      p1_in.tx_busy        = tx_active_in;
      p1_in.rx_available   = (count_in != '0);
      p1_in.rx_overrun     = overrun;
      p1_in.fwd            = push_en && (wr_ptr_ff == rd_ptr_in);
      p1_in.fwd_data       = rx_asm_ff;
   end

   u8n1rxf_ram #(
      .WIDTH ($bits(u8n1rxf_pkg::byte_type)),
      .DEPTH (FIFO_DEPTH)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (fire && push_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (rx_asm_ff),
      .rd_en   (fire),
      .rd_addr (rd_ptr_in),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      p1_entry.tx_line      = p1_ff.tx_line;
      p1_entry.tx_busy      = p1_ff.tx_busy;
      p1_entry.rx_available = p1_ff.rx_available;
      p1_entry.rx_overrun   = p1_ff.rx_overrun;
      if (!p1_ff.rx_available) begin
         p1_entry.rx_data = '0;
      end else if (p1_ff.fwd) begin
         p1_entry.rx_data = p1_ff.fwd_data;
      end else begin
         p1_entry.rx_data = ram_rd_data;
      end
   end

   // Output queue: slot 0 drives rsp, slot 1 is the skid entry.
   always_comb begin
      outq_in[0]  = outq_ff[0];
      outq_in[1]  = outq_ff[1];
      outq_cnt_in = outq_cnt_ff;
      if (rsp_pop) begin
         outq_in[0]  = outq_ff[1];
         outq_cnt_in = outq_cnt_in - 2'd1;
      end
      if (p1_valid_ff) begin
         if ((outq_cnt_ff == 2'd0) || ((outq_cnt_ff == 2'd1) && rsp_pop)) begin
            outq_in[0] = p1_entry;
         end else begin
            outq_in[1] = p1_entry;
         end
         outq_cnt_in = outq_cnt_in + 2'd1;
      end
   end

   assign rsp.valid        = (outq_cnt_ff != 2'd0);
   assign rsp.tx_line      = outq_ff[0].tx_line;
   assign rsp.tx_busy      = outq_ff[0].tx_busy;
   assign rsp.rx_available = outq_ff[0].rx_available;
   assign rsp.rx_data      = outq_ff[0].rx_data;
   assign rsp.rx_overrun   = outq_ff[0].rx_overrun;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff <= u8n1rxf_pkg::BIT_PERIOD_RESET;
         tx_shift_ff   <= u8n1rxf_pkg::TX_IDLE_FRAME;
         tx_bits_ff    <= '0;
         tx_active_ff  <= 1'b0;
         tx_tick_ff    <= '0;
         rx_active_ff  <= 1'b0;
         rx_tick_ff    <= '0;
         rx_slot_ff    <= u8n1rxf_pkg::RX_SLOT_START;
         rx_asm_ff     <= '0;
         rx_prev_ff    <= 1'b1;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
         p1_valid_ff   <= 1'b0;
         outq_cnt_ff   <= '0;
      end else begin
         bit_period_ff <= bit_period_in;
         tx_shift_ff   <= tx_shift_in;
         tx_bits_ff    <= tx_bits_in;
         tx_active_ff  <= tx_active_in;
         tx_tick_ff    <= tx_tick_in;
         rx_active_ff  <= rx_active_in;
         rx_tick_ff    <= rx_tick_in;
         rx_slot_ff    <= rx_slot_in;
         rx_asm_ff     <= rx_asm_in;
         rx_prev_ff    <= rx_prev_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
         p1_valid_ff   <= p1_valid_in;
         outq_cnt_ff   <= outq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff      <= p1_in;
      outq_ff[0] <= outq_in[0];
      outq_ff[1] <= outq_in[1];
   end

   // Assertions.
   `U8_ASSERT_IMP(a_queue_credit, clock, reset, 1'b1, occupancy <= 2'd2)
   `U8_ASSERT_IMP(a_overrun_full, clock, reset, p1_valid_ff && p1_ff.rx_overrun,
                  count_ff == CNT_W'(FIFO_DEPTH))
   `U8_ASSERT_IMP(a_tx_bits_left, clock, reset, tx_active_ff, tx_bits_ff != 4'd0)
   `U8_ASSERT_NXT(a_stall_holds, clock, reset, rsp.valid && !rsp.ready && !p1_valid_ff,
                  $stable(outq_ff[0]))

endmodule

### dv/u8n1rxf_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// UART 8N1 core status scoreboard
// Tracks the transmitter, the receiver and the receive FIFO one tick at a
// time, queues the status word each accepted tick must produce and compares
// the words coming out of the core against that queue in order.
// ----------------------------------------------------------------------------
package u8n1rxf_scoreboard_pkg;

   typedef struct packed {
      logic                  rx_line;
      logic                  tx_valid;
      u8n1rxf_pkg::byte_type tx_data;
      logic                  rx_pop;
   } tick_word_type;

   typedef struct packed {
      logic                  tx_line;
      logic                  tx_busy;
      logic                  rx_available;
      u8n1rxf_pkg::byte_type rx_data;
      logic                  rx_overrun;
   } status_word_type;

   class uart_tick_scoreboard;

      localparam int DEPTH = u8n1rxf_pkg::FIFO_DEPTH_DEFAULT;

      logic [u8n1rxf_pkg::BIT_PERIOD_W-1:0] period;
      int                                   errors;

      logic [9:0]            tx_shift;
      logic [3:0]            tx_left;
      bit                    tx_act;
      logic [15:0]           tx_cnt;
      bit                    rx_act;
      logic [15:0]           rx_cnt;
      logic [3:0]            rx_slot;
      u8n1rxf_pkg::byte_type rx_byte;
      logic                  rx_prev;
      u8n1rxf_pkg::byte_type fifo_mem [DEPTH];
      int                    wr_ptr;
      int                    rd_ptr;
      int                    fill;

      status_word_type status_due_q [$];

      function new();
         period   = u8n1rxf_pkg::BIT_PERIOD_RESET;
         errors   = 0;
         tx_shift = u8n1rxf_pkg::TX_IDLE_FRAME;
         tx_left  = '0;
         tx_act   = 1'b0;
         tx_cnt   = '0;
         rx_act   = 1'b0;
         rx_cnt   = '0;
         rx_slot  = u8n1rxf_pkg::RX_SLOT_START;
         rx_byte  = '0;
         rx_prev  = 1'b1;
         wr_ptr   = 0;
         rd_ptr   = 0;
         fill     = 0;
      endfunction

      function void set_period(logic [u8n1rxf_pkg::BIT_PERIOD_W-1:0] value);
         period = value;
      endfunction

      function int pending();
         return status_due_q.size();
      endfunction

      // Advances the model by one accepted tick and queues its status word.
      function void note_tick(tick_word_type w);
         status_word_type s;
         logic [15:0]     slot_end;
         s = '0;

         if (w.rx_pop && fill > 0) begin
            rd_ptr = (rd_ptr + 1) % DEPTH;
            fill--;
         end

         if (rx_act) begin
            // The start slot only waits half a bit so later samples land mid-bit.
            slot_end = (rx_slot == u8n1rxf_pkg::RX_SLOT_START) ? (period >> 1) : period;
            if (rx_cnt >= slot_end) begin
               rx_cnt = '0;
               if (rx_slot >= u8n1rxf_pkg::RX_SLOT_FIRST &&
                   rx_slot <= u8n1rxf_pkg::RX_SLOT_LAST) begin
                  rx_byte[rx_slot - u8n1rxf_pkg::RX_SLOT_FIRST] = w.rx_line;
                  rx_slot++;
               end else if (rx_slot == u8n1rxf_pkg::RX_SLOT_START) begin
                  rx_slot = u8n1rxf_pkg::RX_SLOT_FIRST;
               end else begin
                  if (fill < DEPTH) begin
                     fifo_mem[wr_ptr] = rx_byte;
                     wr_ptr = (wr_ptr + 1) % DEPTH;
                     fill++;
                  end else begin
                     s.rx_overrun = 1'b1;
                  end
                  rx_act  = 1'b0;
                  rx_slot = u8n1rxf_pkg::RX_SLOT_START;
                  rx_byte = '0;
               end
            end else begin
               rx_cnt++;
            end
         end else if (rx_prev && !w.rx_line) begin
            rx_act  = 1'b1;
            rx_cnt  = '0;
            rx_slot = u8n1rxf_pkg::RX_SLOT_START;
            rx_byte = '0;
         end
         rx_prev = w.rx_line;

         if (tx_act) begin
            if (tx_cnt >= period) begin
               tx_cnt   = '0;
               tx_shift = {1'b1, tx_shift[9:1]};
               if (tx_left > 0) tx_left--;
               if (tx_left == 0) begin
                  tx_act   = 1'b0;
                  tx_shift = u8n1rxf_pkg::TX_IDLE_FRAME;
               end
            end else begin
               tx_cnt++;
            end
         end

         // A byte offered on the tick the previous frame ends is taken at once.
         if (w.tx_valid && !tx_act) begin
            tx_shift = {1'b1, w.tx_data, 1'b0};
            tx_left  = u8n1rxf_pkg::FRAME_BITS;
            tx_cnt   = '0;
            tx_act   = 1'b1;
         end

         s.tx_line      = tx_act ? tx_shift[0] : 1'b1;
         s.tx_busy      = tx_act;
         s.rx_available = (fill > 0);
         s.rx_data      = (fill > 0) ? fifo_mem[rd_ptr] : '0;
         status_due_q.push_back(s);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_status(status_word_type got);
         status_word_type want;
         if (status_due_q.size() == 0) begin
            $error("status word arrived with no tick outstanding");
            errors++;
            return;
         end
         want = status_due_q.pop_front();
         compare_field("tx_line", 8'(want.tx_line), 8'(got.tx_line));
         compare_field("tx_busy", 8'(want.tx_busy), 8'(got.tx_busy));
         compare_field("rx_available", 8'(want.rx_available), 8'(got.rx_available));
         compare_field("rx_data", want.rx_data, got.rx_data);
         compare_field("rx_overrun", 8'(want.rx_overrun), 8'(got.rx_overrun));
      endfunction

   endclass

endpackage

### dv/testbench.sv
// ----------------------------------------------------------------------------
// UART 8N1 core testbench
// Feeds timer ticks carrying serial frames, transmit offers and FIFO pops
// under several bit periods and idle patterns on both channels, and checks
// every status word against a tick-by-tick model of the core.
// ----------------------------------------------------------------------------
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int RSP_HOLD_CYCLES = 60;
   localparam int PACE_WORDS      = 50;

   localparam logic [u8n1rxf_pkg::CSR_ADDR_W-1:0] ADDR_BIT_PERIOD =
      u8n1rxf_pkg::CSR_ADDR_W'(4 * u8n1rxf_pkg::REG_BIT_PERIOD_IDX);

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               csr_psel;
   logic                               csr_penable;
   logic                               csr_pwrite;
   logic [u8n1rxf_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [u8n1rxf_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [u8n1rxf_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                               csr_pready;

   u8n1rxf_req_if req_ch ();
   u8n1rxf_rsp_if rsp_ch ();

   uart_8n1_with_rx_fifo_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   u8n1rxf_scoreboard_pkg::uart_tick_scoreboard sb = new();

   int   words_sent = 0;
   int   pace_mode = 0;
   bit   hold_armed = 1'b0;
   bit   hold_done = 1'b0;
   int   hold_left = 0;
   int   cycles = 0;
   logic line_bits [$];
   int   bit_ticks_left = 0;
   logic line_level = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Pace mode 1 idles the sender, 2 stalls the receiver, 3 does both lightly.
   function automatic int sender_idle_pct();
      return (pace_mode == 1) ? 77 : (pace_mode == 3) ? 18 : 0;
   endfunction

   function automatic int receiver_stall_pct();
      return (pace_mode == 2) ? 77 : (pace_mode == 3) ? 18 : 0;
   endfunction

   always @(posedge clock) begin
      if (hold_armed && !hold_done) begin
         hold_left = RSP_HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct());
      end
   end

   always @(posedge clock) begin
      u8n1rxf_scoreboard_pkg::tick_word_type   tw;
      u8n1rxf_scoreboard_pkg::status_word_type st;
      if (!reset && req_ch.valid && req_ch.ready) begin
         tw.rx_line  = req_ch.rx_line;
         tw.tx_valid = req_ch.tx_valid;
         tw.tx_data  = req_ch.tx_data;
         tw.rx_pop   = req_ch.rx_pop;
         sb.note_tick(tw);
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         st.tx_line      = rsp_ch.tx_line;
         st.tx_busy      = rsp_ch.tx_busy;
         st.rx_available = rsp_ch.rx_available;
         st.rx_data      = rsp_ch.rx_data;
         st.rx_overrun   = rsp_ch.rx_overrun;
         sb.check_status(st);
      end
   end

   // Receive line level for the next tick: mostly whole 8N1 frames held for
   // the current bit period, with short bursts of noise in between.
   function automatic logic next_rx_level();
      u8n1rxf_pkg::byte_type frame_byte;
      int                    n;
      if (bit_ticks_left == 0) begin
         if (line_bits.size() == 0) begin
            if ($urandom_range(99) < 85) begin
               frame_byte = u8n1rxf_pkg::byte_type'($urandom);
               line_bits.push_back(1'b0);
               for (int i = 0; i < 8; i++) line_bits.push_back(frame_byte[i]);
               line_bits.push_back(1'b1);
               n = $urandom_range(2, 1);
               for (int i = 0; i < n; i++) line_bits.push_back(1'b1);
            end else begin
               n = $urandom_range(4, 1);
               for (int i = 0; i < n; i++) line_bits.push_back(logic'($urandom_range(1, 0)));
            end
         end
         line_level     = line_bits.pop_front();
         bit_ticks_left = int'(sb.period) + 1;
      end
      bit_ticks_left--;
      return line_level;
   endfunction

   task automatic send_tick(logic rx_line, logic tx_valid, u8n1rxf_pkg::byte_type tx_data,
                            logic rx_pop);
      while ($urandom_range(99) < sender_idle_pct()) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.rx_line  <= rx_line;
      req_ch.tx_valid <= tx_valid;
      req_ch.tx_data  <= tx_data;
      req_ch.rx_pop   <= rx_pop;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      words_sent++;
      pace_mode = (words_sent / PACE_WORDS) % 4;
   endtask

   task automatic run_random_ticks(int count, int pop_pct, int offer_pct);
      for (int i = 0; i < count; i++) begin
         send_tick(next_rx_level(), ($urandom_range(99) < offer_pct),
                   u8n1rxf_pkg::byte_type'($urandom), ($urandom_range(99) < pop_pct));
      end
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_bit_period(logic [u8n1rxf_pkg::CSR_DATA_W-1:0] value);
      wait_drained();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_BIT_PERIOD;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_period(value[u8n1rxf_pkg::BIT_PERIOD_W-1:0]);
      // Restart the line pattern so it follows the new bit length.
      line_bits.delete();
      bit_ticks_left = 0;
   endtask

   initial begin
      reset           <= 1'b1;
      csr_psel        <= 1'b0;
      csr_penable     <= 1'b0;
      csr_pwrite      <= 1'b0;
      csr_paddr       <= '0;
      csr_pwdata      <= '0;
      req_ch.valid    <= 1'b0;
      req_ch.rx_line  <= 1'b1;
      req_ch.tx_valid <= 1'b0;
      req_ch.tx_data  <= '0;
      req_ch.rx_pop   <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset bit period: a pop of the empty FIFO, a byte taken, a byte
      // offered while busy and a falling edge on the receive line.
      send_tick(1'b1, 1'b1, 8'h00, 1'b1);
      send_tick(1'b0, 1'b1, 8'hFF, 1'b0);
      send_tick(1'b1, 1'b0, 8'hA5, 1'b1);
      send_tick(1'b0, 1'b0, 8'h5A, 1'b0);

      // One tick per bit: receive byte 8'hFC, ending the frame opened above,
      // while a transmit offer is held high across the end of a frame, then pop it.
      write_bit_period(32'h0);
      send_tick(1'b1, 1'b1, 8'h00, 1'b0);
      send_tick(1'b0, 1'b1, 8'h00, 1'b0);
      send_tick(1'b0, 1'b1, 8'h00, 1'b0);
      for (int i = 0; i < 8; i++) send_tick(1'b1, 1'b1, 8'h00, 1'b0);
      send_tick(1'b1, 1'b1, 8'hFF, 1'b0);
      send_tick(1'b1, 1'b1, 8'hFF, 1'b0);
      send_tick(1'b1, 1'b0, 8'h00, 1'b1);
      send_tick(1'b1, 1'b0, 8'h00, 1'b1);

      run_random_ticks(40, 30, 40);

      write_bit_period(32'hABCD_FFFF);
      run_random_ticks(20, 30, 50);

      write_bit_period(32'h1);
      run_random_ticks(40, 30, 30);

      // Fill the FIFO until bytes are dropped; the long output stall lands
      // at the start while ticks keep being offered.
      write_bit_period(32'h0);
      hold_armed = 1'b1;
      run_random_ticks(700, 0, 30);
      run_random_ticks(120, 4, 30);

      write_bit_period(32'h2);
      run_random_ticks(40, 60, 30);

      wait_drained();
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### files.f
+incdir+sv
sv/u8n1rxf_pkg.sv
sv/u8n1rxf_if.sv
sv/u8n1rxf_ram.sv
sv/uart_8n1_with_rx_fifo_core.sv
dv/u8n1rxf_scoreboard_pkg.sv
dv/testbench.sv
